// File: hdl/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

    localparam int PIXEL_W    = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);
    localparam int FW_MIN = 3;
    localparam int FH_MIN = 3;
    localparam int FH_MAX = 4096;

    localparam int WIN_N      = 3;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;
    localparam int LS_W       = 2 * PIXEL_W;

    // floor(x/9) = (x * ceil(2^16/9)) >> 16, exact for x < 2^13
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

    typedef struct packed {
        logic                 emit;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 done;
    } bmf_meta_t;

endpackage

`default_nettype wire

// File: hdl/bmf_stream_if.sv
`default_nettype none

interface bmf_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [bmf_pkg::PIXEL_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bmf_result_if;
    logic                            valid;
    logic                            ready;
    logic [bmf_pkg::PIXEL_W-1:0]     mean_value;
    logic [bmf_pkg::ROW_W-1:0]       out_row;
    logic [bmf_pkg::COL_OUT_W-1:0]   out_col;
    logic                            frame_done;

    modport source (output valid, output mean_value, output out_row, output out_col,
                    output frame_done, input ready);
    modport sink   (input valid, input mean_value, input out_row, input out_col,
                    input frame_done, output ready);
endinterface

`default_nettype wire

// File: hdl/bmf_line_store.sv
`default_nettype none

module bmf_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [bmf_pkg::LS_W-1:0]   rd_data,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [bmf_pkg::LS_W-1:0]   wr_data
);
    import bmf_pkg::*;

    logic [LS_W-1:0] store_reg [DEPTH];
    logic [LS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/bmf_col_cell.sv
`default_nettype none

module bmf_col_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire logic [bmf_pkg::COLSUM_W-1:0]  col_sum_in,
    output logic      [bmf_pkg::COLSUM_W-1:0]  col_sum
);
    import bmf_pkg::*;

    logic [COLSUM_W-1:0] col_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sum_reg <= '0;
        end
        else if (shift)
        begin
            col_sum_reg <= col_sum_in;
        end
    end

    assign col_sum = col_sum_reg;

endmodule

`default_nettype wire

// File: hdl/box_mean_filter_3x3.sv
// Channel   Dir  Type             Carries
// pix_in    in   bmf_pixel_if     one grey pixel per transaction, raster order
// res_out   out  bmf_result_if    mean, centre row/col and end-of-frame flag
// APB       in   psel..pready     frame_width at 0x0, frame_height at 0x4
//
// One pixel per cycle unless output stalls; a result passes s1, s2, s3 and
// the output register. Line stores are one 16-bit RAM read on acceptance,
// written back from s1; the window is a chain of three column-sum cells.
// Reset clears counters, window and valid flags; the RAM needs no clearing.
// A stalled output register holds the whole pipeline and drops pix_in.ready.
`default_nettype none

module box_mean_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    bmf_pixel_if.sink                              pix_in,
    bmf_result_if.source                           res_out
);
    import bmf_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;

    logic [CW-1:0]    col_cnt_reg;
    logic [CW-1:0]    col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;
    logic             col_last;
    logic             row_last;

    logic      adv;
    logic      accept;
    bmf_meta_t meta_next;

    logic                 s1_valid_reg;
    logic [PIXEL_W-1:0]   s1_pixel_reg;
    logic [CW-1:0]        s1_col_reg;
    bmf_meta_t            s1_meta_reg;
    logic [LS_W-1:0]      ls_rd_data;
    logic [PIXEL_W-1:0]   ls_upper;
    logic [PIXEL_W-1:0]   ls_middle;

    logic                 s2_valid_reg;
    bmf_meta_t            s2_meta_reg;
    logic [COLSUM_W-1:0]  cell_in  [WIN_N];
    logic [COLSUM_W-1:0]  cell_out [WIN_N];

    logic                 s3_valid_reg;
    bmf_meta_t            s3_meta_reg;
    logic [SUM_W-1:0]     s3_sum_reg;
    logic [PROD_W-1:0]    product;

    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_mean_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic                 out_done_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (32'(frame_width_reg) < FW_MIN)
        begin
            eff_w = WW'(FW_MIN);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end

        priority if (32'(frame_height_reg) < FH_MIN)
        begin
            eff_h = FH_W'(FH_MIN);
        end
        else if (32'(frame_height_reg) > FH_MAX)
        begin
            eff_h = FH_W'(FH_MAX);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    // ---------------- raster counters ----------------
    assign adv    = !out_valid_reg || res_out.ready;
    assign accept = pix_in.valid && adv;
    assign pix_in.ready = adv;

    always_comb
    begin
        col_last = (32'(col_cnt_reg) + 32'd1) >= 32'(eff_w);
        row_last = (32'(row_cnt_reg) + 32'd1) >= 32'(eff_h);
        col_cnt_next = col_last ? '0 : col_cnt_reg + CW'(1);
        if (col_last)
        begin
            row_cnt_next = row_last ? '0 : row_cnt_reg + ROW_W'(1);
        end
        else
        begin
            row_cnt_next = row_cnt_reg;
        end

        meta_next.emit = (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg >= CW'(2));
        meta_next.row  = row_cnt_reg - ROW_W'(1);
        meta_next.col  = COL_OUT_W'(col_cnt_reg - CW'(1));
        meta_next.done = ((32'(row_cnt_reg) + 32'd1) == 32'(eff_h))
                      && ((32'(col_cnt_reg) + 32'd1) == 32'(eff_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- stage 1: pixel in, line store read ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pix_in.pixel;
            s1_col_reg   <= col_cnt_reg;
            s1_meta_reg  <= meta_next;
        end
    end

    bmf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (ls_rd_data),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({ls_middle, s1_pixel_reg})
    );

    assign ls_upper  = ls_rd_data[LS_W-1:PIXEL_W];
    assign ls_middle = ls_rd_data[PIXEL_W-1:0];

    // ---------------- stage 2: window of column sums ----------------
    assign cell_in[WIN_N-1] = COLSUM_W'(ls_upper) + COLSUM_W'(ls_middle)
                            + COLSUM_W'(s1_pixel_reg);

    for (genvar k = 0; k < WIN_N; k++)
    begin : g_cell
        if (k < WIN_N - 1)
        begin : g_link
            assign cell_in[k] = cell_out[k+1];
        end

        bmf_col_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (adv && s1_valid_reg),
            .col_sum_in (cell_in[k]),
            .col_sum    (cell_out[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
            s3_meta_reg <= s2_meta_reg;
            s3_sum_reg  <= SUM_W'(cell_out[0]) + SUM_W'(cell_out[1]) + SUM_W'(cell_out[2]);
        end
    end

    // ---------------- stage 3: divide by nine ----------------
    assign product = PROD_W'(s3_sum_reg) * PROD_W'(RECIP_NINE);

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            out_mean_reg <= product[RECIP_SHIFT +: PIXEL_W];
            out_row_reg  <= s3_meta_reg.row;
            out_col_reg  <= s3_meta_reg.col;
            out_done_reg <= s3_meta_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pix_in.valid;
            s2_valid_reg  <= s1_valid_reg && s1_meta_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.mean_value = out_mean_reg;
    assign res_out.out_row    = out_row_reg;
    assign res_out.out_col    = out_col_reg;
    assign res_out.frame_done = out_done_reg;

endmodule

`default_nettype wire
